// ===== rtl/core/lcdseq_pkg.sv =====
// lcdseq_pkg: types, display instruction codes and the setup table
// shared by the character-lcd command sequencer modules; no dependencies
`timescale 1ns / 1ps

package lcdseq_pkg;

  localparam int unsigned MAX_COLUMN_DEF = 40;
  localparam int unsigned MAX_BLANKS     = 40;
  localparam int unsigned SETUP_WRITES   = 8;

  // display instruction and data codes
  localparam logic [7:0] INS_CLEAR       = 8'h01;
  localparam logic [7:0] INS_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] INS_DISP_OFF    = 8'h08;
  localparam logic [7:0] INS_DISP_ON     = 8'h0c;
  localparam logic [7:0] INS_SHIFT       = 8'h10;
  localparam logic [7:0] INS_FUNC_8BIT   = 8'h30;
  localparam logic [7:0] INS_FUNC_2LINE  = 8'h38;
  localparam logic [7:0] INS_SET_CGRAM   = 8'h40;
  localparam logic [7:0] INS_SET_DDRAM   = 8'h80;
  localparam logic [7:0] ROW1_OFFSET     = 8'h40;
  localparam logic [7:0] CHR_BLANK       = 8'h20;
  localparam logic [7:0] CHR_DIGIT0      = 8'h30;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_CURSOR  = 3'd1,
    ACT_SECTION = 3'd2,
    ACT_SHIFT   = 3'd3,
    ACT_GLYPH   = 3'd4,
    ACT_CHAR    = 3'd5,
    ACT_NUMBER  = 3'd6,
    ACT_SETUP   = 3'd7
  } action_t;

  typedef struct packed {
    action_t     action;
    logic        bottom_row;
    logic [7:0]  column;
    logic [7:0]  length;
    logic [7:0]  char_code;
    logic [15:0] number;
    logic        shift_right;
  } cmd_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       poll_busy;
    logic [3:0] wait_ms;
    logic       last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_step;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_last;
    logic emit_last;
  } dp_status_t;

  // power-on sequence; last flag is filled in by the datapath
  function automatic res_t setup_write(input logic [2:0] step);
    res_t r;
    r = '{bus_byte: INS_FUNC_8BIT, is_data: 1'b0, poll_busy: 1'b1,
          wait_ms: 4'd0, last: 1'b0};
    unique case (step)
      3'd0: begin
        r.poll_busy = 1'b0;
        r.wait_ms   = 4'd15;
      end
      3'd1: begin
        r.poll_busy = 1'b0;
        r.wait_ms   = 4'd5;
      end
      3'd2: begin
        r.poll_busy = 1'b0;
        r.wait_ms   = 4'd1;
      end
      3'd3: r.bus_byte = INS_FUNC_2LINE;
      3'd4: r.bus_byte = INS_DISP_OFF;
      3'd5: r.bus_byte = INS_CLEAR;
      3'd6: r.bus_byte = INS_ENTRY_MODE;
      3'd7: r.bus_byte = INS_DISP_ON;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/lcdseq_datapath.sv =====
// lcdseq_datapath: command register, write index, binary-to-bcd converter
// and registered result output; depends on lcdseq_pkg
`timescale 1ns / 1ps

module lcdseq_datapath import lcdseq_pkg::*; #(
  parameter int unsigned MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  ctl_cmd_t   ctl,
  output dp_status_t status,
  output logic       strobe,
  output res_t       result
);

  cmd_t        cmd_q;
  logic [5:0]  idx;
  logic [19:0] bcd;
  logic [15:0] bin;
  logic [3:0]  bit_cnt;

  logic [19:0] bcd_adj;
  logic [7:0]  col_cl;
  logic [7:0]  cursor_byte;
  logic [5:0]  len_sat;
  logic [5:0]  n_writes;
  logic [2:0]  ndig;
  logic [2:0]  pos;
  logic [3:0]  digit;
  res_t        cur;

  // add-3 correction on each bcd digit
  always_comb begin
    for (int d = 0; d < 5; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? bcd[d*4 +: 4] + 4'd3
                                                  : bcd[d*4 +: 4];
    end
  end

  assign col_cl      = (cmd_q.column > 8'(MAX_COLUMN)) ? 8'(MAX_COLUMN) : cmd_q.column;
  assign cursor_byte = INS_SET_DDRAM | col_cl + (cmd_q.bottom_row ? ROW1_OFFSET : 8'h00);
  assign len_sat     = (cmd_q.length > 8'(MAX_BLANKS)) ? 6'(MAX_BLANKS) : cmd_q.length[5:0];

  always_comb begin
    priority if (bcd[19:16] != 4'd0) ndig = 3'd5;
    else if (bcd[15:12] != 4'd0)     ndig = 3'd4;
    else if (bcd[11:8] != 4'd0)      ndig = 3'd3;
    else if (bcd[7:4] != 4'd0)       ndig = 3'd2;
    else                             ndig = 3'd1;
  end

  assign pos = ndig - 3'd1 - idx[2:0];

  always_comb begin
    unique case (pos)
      3'd0:    digit = bcd[3:0];
      3'd1:    digit = bcd[7:4];
      3'd2:    digit = bcd[11:8];
      3'd3:    digit = bcd[15:12];
      3'd4:    digit = bcd[19:16];
      default: digit = 4'd0;
    endcase
  end

  always_comb begin
    cur = '{bus_byte: INS_CLEAR, is_data: 1'b0, poll_busy: 1'b1,
            wait_ms: 4'd0, last: 1'b0};
    n_writes = 6'd1;
    unique case (cmd_q.action)
      ACT_CLEAR:  cur.bus_byte = INS_CLEAR;
      ACT_CURSOR: cur.bus_byte = cursor_byte;
      ACT_SECTION: begin
        n_writes = len_sat + 6'd2;
        if (idx == 6'd0 || idx == len_sat + 6'd1) begin
          cur.bus_byte = cursor_byte;
        end else begin
          cur.bus_byte = CHR_BLANK;
          cur.is_data  = 1'b1;
        end
      end
      ACT_SHIFT:  cur.bus_byte = INS_SHIFT | {7'd0, cmd_q.shift_right};
      ACT_GLYPH:  cur.bus_byte = INS_SET_CGRAM | {2'b00, cmd_q.char_code[2:0], 3'b000};
      ACT_CHAR: begin
        cur.bus_byte = cmd_q.char_code;
        cur.is_data  = 1'b1;
      end
      ACT_NUMBER: begin
        n_writes     = {3'd0, ndig};
        cur.bus_byte = CHR_DIGIT0 | {4'd0, digit};
        cur.is_data  = 1'b1;
      end
      ACT_SETUP: begin
        n_writes = 6'(SETUP_WRITES);
        cur      = setup_write(idx[2:0]);
      end
    endcase
    cur.last = (idx == n_writes - 6'd1);
  end

  assign status.conv_last = (bit_cnt == 4'd15);
  assign status.emit_last = cur.last;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= cmd;
      idx     <= 6'd0;
      bin     <= cmd.number;
      bcd     <= 20'd0;
      bit_cnt <= 4'd0;
    end else begin
      if (ctl.conv_step) begin
        bcd     <= {bcd_adj[18:0], bin[15]};
        bin     <= {bin[14:0], 1'b0};
        bit_cnt <= bit_cnt + 4'd1;
      end
      if (ctl.emit_step) begin
        idx <= idx + 6'd1;
      end
    end
    if (ctl.emit_step) begin
      result <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit_step;
    end
  end

  a_strobe_follows_emit: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_step |=> strobe) else $error("write issued but no strobe");
  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (rst)
    !ctl.emit_step |=> !strobe) else $error("strobe without a write");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe) else $error("write right after last");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_step |-> idx <= 6'(MAX_BLANKS + 1)) else $error("write index overrun");
  a_conv_number: assert property (@(posedge clk) disable iff (rst)
    ctl.conv_step |-> cmd_q.action == ACT_NUMBER) else $error("conversion on non-number");

endmodule

// ===== rtl/core/lcdseq_ctrl.sv =====
// lcdseq_ctrl: one-hot controller that sequences load, bcd conversion
// and write issue; depends on lcdseq_pkg
`timescale 1ns / 1ps

module lcdseq_ctrl import lcdseq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       is_number,
  input  dp_status_t status,
  output ctl_cmd_t   ctl,
  output logic       busy
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = is_number ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        ctl.conv_step = 1'b1;
        if (status.conv_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.emit_step = 1'b1;
        if (status.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/char_lcd_command_sequencer.sv =====
// char_lcd_command_sequencer: top level, turns one display command into its
// ordered bus writes; depends on lcdseq_pkg, lcdseq_ctrl, lcdseq_datapath
//
//  channel   | ports                  | transaction when
//  ----------+------------------------+----------------------------------
//  command   | start, busy, cmd       | start high while busy low
//  write     | strobe, result         | every cycle strobe is high
//
// a command is taken while idle, then one bus write is issued per cycle
// and shown on the output register the cycle after; clear section with 40
// blanks gives 42 writes, the longest run
// number first runs a double-dabble conversion of all 16 bits, then 1 to 5 digits
// busy stays high until the final write is issued; the next command can be
// taken while that final write is still on the outputs
// synchronous reset returns the controller to idle and drops strobe
// the write side cannot stall: each write is valid for exactly one cycle
`timescale 1ns / 1ps

module char_lcd_command_sequencer import lcdseq_pkg::*; #(
  parameter int unsigned MAX_COLUMN = MAX_COLUMN_DEF  // highest cursor column
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic strobe,
  output res_t result
);

  ctl_cmd_t   ctl;     // controller commands to the datapath
  dp_status_t status;  // end-of-conversion and final-write flags

  // controller: idle, conversion and write-issue phases
  lcdseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .is_number (cmd.action == ACT_NUMBER),
    .status    (status),
    .ctl       (ctl),
    .busy      (busy)
  );

  // datapath: holds the command, builds each write and registers it out
  lcdseq_datapath #(
    .MAX_COLUMN (MAX_COLUMN)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule
